@@ hw/rtl/dbst_pkg.sv @@
// shared types, constants and helpers for the breakpoint slot table
`timescale 1ns / 1ps

package dbst_pkg;

  localparam int SLOTS      = 4;
  localparam int SLOT_IDX_W = $clog2(SLOTS);
  localparam int ADDR_WIDTH = 64;
  localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_WIDTH);

  localparam int RW_BASE  = 16;
  localparam int LEN_BASE = 18;
  localparam logic [1:0] RW_READ  = 2'd3;
  localparam logic [1:0] RW_WRITE = 2'd1;

  typedef struct packed {
    logic [63:0] watch_address;
    logic [3:0]  watch_size;
    logic        on_read;
  } in_t;

  typedef struct packed {
    logic [31:0] control_word;
    logic [63:0] slot0_address;
    logic [63:0] slot1_address;
    logic [63:0] slot2_address;
    logic [63:0] slot3_address;
  } out_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [3:0]  size;
    logic        rd;
  } slot_t;

  typedef enum logic [1:0] {
    SOP_NONE,
    SOP_CLEAR,
    SOP_WRITE,
    SOP_EVICT
  } slot_op_t;

  typedef struct packed {
    slot_op_t                op;
    logic [SLOT_IDX_W-1:0]   tgt;
    slot_t                   entry;
  } slot_cmd_t;

  typedef struct packed {
    slot_cmd_t cmd;
    logic      report;
  } ctrl_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_REPORT
  } ctrl_state_t;

  function automatic logic [1:0] len_code(input logic [3:0] size);
    logic [1:0] code;
    case (size)
      4'd2:    code = 2'd1;
      4'd4:    code = 2'd3;
      4'd8:    code = 2'd2;
      default: code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

@@ hw/rtl/dbst_slots.sv @@
// slot register file with shift, write and evict operations and the dr7 view
`timescale 1ns / 1ps

module dbst_slots (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dbst_pkg::slot_cmd_t             cmd,
  input  logic [dbst_pkg::SLOT_IDX_W-1:0] scan_idx,
  output logic [63:0]                     scan_addr,
  output dbst_pkg::out_t                  view
);

  dbst_pkg::slot_t slots_r   [dbst_pkg::SLOTS];
  dbst_pkg::slot_t slots_nxt [dbst_pkg::SLOTS];
  logic [31:0]     word;

  assign scan_addr = slots_r[scan_idx].addr;

  always_comb begin
    for (int k = 0; k < dbst_pkg::SLOTS; k++) begin
      slots_nxt[k] = slots_r[k];
    end
    case (cmd.op)
      dbst_pkg::SOP_CLEAR: begin
        // remove the target, close the gap, empty the last slot
        for (int k = 0; k < dbst_pkg::SLOTS - 1; k++) begin
          if (k >= int'(cmd.tgt)) begin
            slots_nxt[k] = slots_r[k + 1];
          end
        end
        slots_nxt[dbst_pkg::SLOTS - 1] = '0;
      end
      dbst_pkg::SOP_WRITE: begin
        slots_nxt[cmd.tgt] = cmd.entry;
      end
      dbst_pkg::SOP_EVICT: begin
        // oldest entry drops out, new one lands in the last slot
        for (int k = 0; k < dbst_pkg::SLOTS - 1; k++) begin
          slots_nxt[k] = slots_r[k + 1];
        end
        slots_nxt[dbst_pkg::SLOTS - 1] = cmd.entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < dbst_pkg::SLOTS; k++) begin
        slots_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < dbst_pkg::SLOTS; k++) begin
        slots_r[k] <= slots_nxt[k];
      end
    end
  end

  always_comb begin
    word = '0;
    for (int i = 0; i < dbst_pkg::SLOTS; i++) begin
      if (slots_r[i].addr != '0 && slots_r[i].size != '0) begin
        word[2*i] = 1'b1;
        word[dbst_pkg::RW_BASE + 4*i +: 2] =
          slots_r[i].rd ? dbst_pkg::RW_READ : dbst_pkg::RW_WRITE;
        word[dbst_pkg::LEN_BASE + 4*i +: 2] = dbst_pkg::len_code(slots_r[i].size);
      end
    end
  end

  assign view.control_word  = word;
  assign view.slot0_address = slots_r[0].addr;
  assign view.slot1_address = slots_r[1].addr;
  assign view.slot2_address = slots_r[2].addr;
  assign view.slot3_address = slots_r[3].addr;

endmodule

@@ hw/rtl/dbst_ctrl.sv @@
// request sequencer: walks the slots through one shared address comparator
`timescale 1ns / 1ps

module dbst_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  dbst_pkg::in_t                   req,
  input  logic [63:0]                     scan_addr,
  output logic [dbst_pkg::SLOT_IDX_W-1:0] scan_idx,
  output logic                            busy,
  output dbst_pkg::ctrl_stat_t            stat
);

  localparam logic [dbst_pkg::SLOT_IDX_W-1:0] LAST_IDX =
    dbst_pkg::SLOT_IDX_W'(dbst_pkg::SLOTS - 1);

  dbst_pkg::ctrl_state_t               state_r, state_nxt;
  logic [dbst_pkg::SLOT_IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic [dbst_pkg::SLOT_IDX_W-1:0]     tgt_r, tgt_nxt;
  logic                                found_r, found_nxt;
  dbst_pkg::slot_t                     req_r, req_nxt;
  logic                                clr_mode;
  logic                                addr_eq;
  logic                                slot_empty;
  logic                                hit;

  assign clr_mode   = (req_r.size == '0);
  // the one shared comparator
  assign addr_eq    = (scan_addr == req_r.addr);
  assign slot_empty = (scan_addr == '0);
  assign hit        = addr_eq || (!clr_mode && slot_empty);

  assign scan_idx = scan_idx_r;
  assign busy     = (state_r != dbst_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dbst_pkg::ST_IDLE;
      scan_idx_r <= '0;
      tgt_r      <= '0;
      found_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      tgt_r      <= tgt_nxt;
      found_r    <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    scan_idx_nxt    = scan_idx_r;
    tgt_nxt         = tgt_r;
    found_nxt       = found_r;
    req_nxt         = req_r;
    stat.cmd.op     = dbst_pkg::SOP_NONE;
    stat.cmd.tgt    = tgt_r;
    stat.cmd.entry  = req_r;
    stat.report     = 1'b0;
    case (state_r)
      dbst_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt.addr = req.watch_address & dbst_pkg::ADDR_MASK;
          req_nxt.size = req.watch_size;
          req_nxt.rd   = req.on_read;
          scan_idx_nxt = '0;
          state_nxt    = dbst_pkg::ST_SCAN;
        end
      end
      dbst_pkg::ST_SCAN: begin
        if (hit) begin
          tgt_nxt   = scan_idx_r;
          found_nxt = 1'b1;
          state_nxt = dbst_pkg::ST_UPDATE;
        end else if (scan_idx_r == LAST_IDX) begin
          tgt_nxt   = LAST_IDX;
          found_nxt = 1'b0;
          state_nxt = dbst_pkg::ST_UPDATE;
        end else begin
          scan_idx_nxt = scan_idx_r + dbst_pkg::SLOT_IDX_W'(1);
        end
      end
      dbst_pkg::ST_UPDATE: begin
        if (clr_mode) begin
          stat.cmd.op = found_r ? dbst_pkg::SOP_CLEAR : dbst_pkg::SOP_NONE;
        end else begin
          stat.cmd.op = found_r ? dbst_pkg::SOP_WRITE : dbst_pkg::SOP_EVICT;
        end
        state_nxt = dbst_pkg::ST_REPORT;
      end
      dbst_pkg::ST_REPORT: begin
        stat.report = 1'b1;
        state_nxt   = dbst_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dbst_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == dbst_pkg::ST_SCAN && scan_idx_r == '0))
    else $error("accepted request did not start scanning at slot 0");

  a_hit_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dbst_pkg::ST_SCAN && hit)
      |=> (state_r == dbst_pkg::ST_UPDATE && found_r && tgt_r == $past(scan_idx_r)))
    else $error("scan hit not captured as update target");

  a_update_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dbst_pkg::ST_UPDATE) |=> (state_r == dbst_pkg::ST_REPORT))
    else $error("update not followed by report");

  a_no_slot_op_while_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != dbst_pkg::ST_UPDATE) |-> (stat.cmd.op == dbst_pkg::SOP_NONE))
    else $error("slot table changed outside the update step");

endmodule

@@ hw/rtl/debug_breakpoint_slot_table_core.sv @@
// top level of the data breakpoint slot table with dr7 control word output
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. The sequencer then
// compares the request address against the slots one per cycle through a
// single shared comparator, stopping at the first hit, applies the slot
// update and captures the result in the following cycle. A request scans
// 1 to 4 slots. The result shows on out_data for exactly one cycle with
// out_valid high, starting the cycle busy falls; the receiver cannot stall
// it, and a new request may be started in that same cycle.
module debug_breakpoint_slot_table_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dbst_pkg::in_t  in_data,
  output logic           out_valid,
  output dbst_pkg::out_t out_data
);

  logic [dbst_pkg::SLOT_IDX_W-1:0] scan_idx;
  logic [63:0]                     scan_addr;
  dbst_pkg::ctrl_stat_t            stat;
  dbst_pkg::out_t                  view;
  dbst_pkg::out_t                  out_data_r;
  logic                            out_valid_r;

  dbst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (in_data),
    .scan_addr (scan_addr),
    .scan_idx  (scan_idx),
    .busy      (busy),
    .stat      (stat)
  );

  dbst_slots u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stat.cmd),
    .scan_idx  (scan_idx),
    .scan_addr (scan_addr),
    .view      (view)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stat.report;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.report) begin
      out_data_r <= view;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
